FILE: sv/crrs_pkg.sv
// ----------------------------------------------------------------------------
// crrs_pkg
// Sizes, codes, controller states, datapath commands and queue addressing
// for the container round-robin scheduler.
// ----------------------------------------------------------------------------
package crrs_pkg;

  localparam int MAX_CONTAINERS = 16;
  localparam int QUEUE_DEPTH    = 16;
  localparam int TASK_ID_BITS   = 16;

  localparam int SLOT_W    = $clog2(MAX_CONTAINERS);
  localparam int POS_W     = $clog2(QUEUE_DEPTH);
  localparam int CNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int RAM_DEPTH = MAX_CONTAINERS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(RAM_DEPTH);
  localparam int TASK_W    = TASK_ID_BITS;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_SWITCH = 2'd1,
    REQ_DELETE = 2'd2,
    REQ_NOP    = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    STAT_DONE     = 3'd0,
    STAT_NO_CONT  = 3'd1,
    STAT_NO_TASK  = 3'd2,
    STAT_FULL     = 3'd3,
    STAT_SOLE     = 3'd4
  } status_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_KEY_SCAN, ST_CREATE, ST_DEL_EVAL, ST_DEL_RD, ST_DEL_CMP,
    ST_DEL_HIT, ST_SW_SLOT, ST_SW_RD, ST_SW_CMP, ST_SW_EVAL, ST_SH_CHK,
    ST_SH_RD, ST_SH_WR, ST_SH_END, ST_WAKE_RD, ST_WAKE_CAP, ST_DONE
  } ctrl_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_KEY_STEP, OP_CREATE, OP_DEL_EVAL, OP_TASK_RD,
    OP_DEL_CMP, OP_DEL_HIT, OP_SW_SEL, OP_S_INC, OP_SW_CMP, OP_SW_EVAL,
    OP_SH_RD, OP_SH_WR, OP_SH_END, OP_WAKE_RD, OP_WAKE_CAP, OP_PUBLISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    req_t req;
    logic s_last;
    logic slot_ok;
    logic match;
    logic i_last;
    logic best_hit;
    logic best_single;
    logic bpos_zero;
    logic key_hit;
    logic key_single;
    logic sh_more;
  } dp_status_t;

  function automatic logic [POS_W-1:0] next_pos(logic [POS_W-1:0] head);
    return (head == POS_W'(QUEUE_DEPTH - 1)) ? '0 : head + POS_W'(1);
  endfunction

  function automatic logic [ADDR_W-1:0] qaddr(logic [SLOT_W-1:0] slot,
                                              logic [POS_W-1:0]  head,
                                              logic [CNT_W-1:0]  idx);
    logic [CNT_W:0]   sum;
    logic [POS_W-1:0] pos;
    sum = (CNT_W+1)'(head) + (CNT_W+1)'(idx);
    if (sum >= (CNT_W+1)'(QUEUE_DEPTH)) sum = sum - (CNT_W+1)'(QUEUE_DEPTH);
    pos = sum[POS_W-1:0];
    return ADDR_W'(slot) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(pos);
  endfunction

endpackage

FILE: sv/container_round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// container_round_robin_scheduler
// Container table with per-container round-robin task queues; one result
// per request.
// ----------------------------------------------------------------------------
// One request is in flight at a time. Create and delete first walk the
// container table one slot a cycle. Switch walks the queue of every live
// container through the single read port of the queue RAM; removing a task
// from the middle of a queue compacts it by reading each later entry and
// writing it one place forward. A finished result is held in an output
// register, and the next request is taken while it waits.
// Queue memory is not cleared at reset; only written entries are ever read.
// ----------------------------------------------------------------------------
module container_round_robin_scheduler import crrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_container_id,
  input  logic [15:0] in_task_id,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic        out_wake_valid,
  output logic [15:0] out_wake_task,
  output logic        out_caller_sleeps,
  output logic [4:0]  out_task_count
);

  dp_cmd_t    cmd;
  dp_status_t st;

  crrs_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .st          (st),
    .cmd         (cmd)
  );

  crrs_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_req_type       (in_req_type),
    .in_container_id   (in_container_id),
    .in_task_id        (in_task_id),
    .st                (st),
    .out_status        (out_status),
    .out_wake_valid    (out_wake_valid),
    .out_wake_task     (out_wake_task),
    .out_caller_sleeps (out_caller_sleeps),
    .out_task_count    (out_task_count)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while another is in flight");

  a_wake_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_wake_valid) |->
      (out_status == STAT_DONE && out_task_count != 5'd0))
    else $error("wake reported without a live queue");

  a_sleep_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_caller_sleeps) |-> (out_task_count > 5'd1))
    else $error("caller sleeps in a queue of one");

endmodule

FILE: sv/crrs_ram.sv
// ----------------------------------------------------------------------------
// crrs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module crrs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/crrs_ctrl.sv
// ----------------------------------------------------------------------------
// crrs_ctrl
// Request sequencer: walks the container table and queues through the
// datapath and owns the input and result handshakes.
// ----------------------------------------------------------------------------
module crrs_ctrl import crrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  output logic       out_valid,
  input  logic       out_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (req_t'(in_req_type))
            REQ_CREATE, REQ_DELETE: state_nxt = ST_KEY_SCAN;
            REQ_SWITCH:             state_nxt = ST_SW_SLOT;
            REQ_NOP:                state_nxt = ST_DONE;
            default:                state_nxt = ST_DONE;
          endcase
        end
      end
      ST_KEY_SCAN: begin
        if (st.s_last) state_nxt = (st.req == REQ_CREATE) ? ST_CREATE : ST_DEL_EVAL;
      end
      ST_CREATE:   state_nxt = ST_DONE;
      ST_DEL_EVAL: state_nxt = (!st.key_hit || st.key_single) ? ST_DONE : ST_DEL_RD;
      ST_DEL_RD:   state_nxt = ST_DEL_CMP;
      ST_DEL_CMP: begin
        priority if (st.match) state_nxt = ST_DEL_HIT;
        else if (st.i_last)    state_nxt = ST_DONE;
        else                   state_nxt = ST_DEL_RD;
      end
      ST_DEL_HIT:  state_nxt = st.bpos_zero ? ST_WAKE_RD : ST_SH_CHK;
      ST_SW_SLOT: begin
        if (st.slot_ok)     state_nxt = ST_SW_RD;
        else if (st.s_last) state_nxt = ST_SW_EVAL;
      end
      ST_SW_RD:    state_nxt = ST_SW_CMP;
      ST_SW_CMP: begin
        if (st.match || st.i_last) state_nxt = st.s_last ? ST_SW_EVAL : ST_SW_SLOT;
        else                       state_nxt = ST_SW_RD;
      end
      ST_SW_EVAL: begin
        priority if (!st.best_hit || st.best_single) state_nxt = ST_DONE;
        else if (st.bpos_zero)                       state_nxt = ST_WAKE_RD;
        else                                         state_nxt = ST_SH_CHK;
      end
      ST_SH_CHK:   state_nxt = st.sh_more ? ST_SH_RD : ST_SH_END;
      ST_SH_RD:    state_nxt = ST_SH_WR;
      ST_SH_WR:    state_nxt = ST_SH_CHK;
      ST_SH_END:   state_nxt = ST_WAKE_RD;
      ST_WAKE_RD:  state_nxt = ST_WAKE_CAP;
      ST_WAKE_CAP: state_nxt = ST_DONE;
      ST_DONE: begin
        if (!out_valid_r || out_ready) state_nxt = ST_IDLE;
      end
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.op        = OP_NONE;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = OP_LOAD;
      end
      ST_KEY_SCAN: cmd.op = OP_KEY_STEP;
      ST_CREATE:   cmd.op = OP_CREATE;
      ST_DEL_EVAL: cmd.op = OP_DEL_EVAL;
      ST_DEL_RD:   cmd.op = OP_TASK_RD;
      ST_DEL_CMP:  cmd.op = OP_DEL_CMP;
      ST_DEL_HIT:  cmd.op = OP_DEL_HIT;
      ST_SW_SLOT:  cmd.op = st.slot_ok ? OP_SW_SEL : OP_S_INC;
      ST_SW_RD:    cmd.op = OP_TASK_RD;
      ST_SW_CMP:   cmd.op = OP_SW_CMP;
      ST_SW_EVAL:  cmd.op = OP_SW_EVAL;
      ST_SH_CHK:   cmd.op = OP_NONE;
      ST_SH_RD:    cmd.op = OP_SH_RD;
      ST_SH_WR:    cmd.op = OP_SH_WR;
      ST_SH_END:   cmd.op = OP_SH_END;
      ST_WAKE_RD:  cmd.op = OP_WAKE_RD;
      ST_WAKE_CAP: cmd.op = OP_WAKE_CAP;
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_PUBLISH;
          out_valid_nxt = 1'b1;
        end
      end
      default:     cmd.op = OP_NONE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/crrs_dp.sv
// ----------------------------------------------------------------------------
// crrs_dp
// Container table, task queue memory, scan counters and result registers.
// ----------------------------------------------------------------------------
module crrs_dp import crrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dp_cmd_t     cmd,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_container_id,
  input  logic [15:0] in_task_id,
  output dp_status_t  st,
  output logic [2:0]  out_status,
  output logic        out_wake_valid,
  output logic [15:0] out_wake_task,
  output logic        out_caller_sleeps,
  output logic [4:0]  out_task_count
);

  logic              valid_r [MAX_CONTAINERS];
  logic              valid_nxt [MAX_CONTAINERS];
  logic [31:0]       key_r [MAX_CONTAINERS];
  logic [31:0]       key_nxt [MAX_CONTAINERS];
  logic [SLOT_W-1:0] rank_r [MAX_CONTAINERS];
  logic [SLOT_W-1:0] rank_nxt [MAX_CONTAINERS];
  logic [CNT_W-1:0]  count_r [MAX_CONTAINERS];
  logic [CNT_W-1:0]  count_nxt [MAX_CONTAINERS];
  logic [POS_W-1:0]  head_r [MAX_CONTAINERS];
  logic [POS_W-1:0]  head_nxt [MAX_CONTAINERS];

  req_t              req_r, req_nxt;
  logic [31:0]       rkey_r, rkey_nxt;
  logic [TASK_W-1:0] task_r, task_nxt;
  logic [SLOT_W-1:0] s_idx_r, s_idx_nxt;
  logic [SLOT_W-1:0] cur_r, cur_nxt;
  logic [CNT_W-1:0]  i_r, i_nxt;
  logic              key_hit_r, key_hit_nxt;
  logic [SLOT_W-1:0] key_slot_r, key_slot_nxt;
  logic              free_hit_r, free_hit_nxt;
  logic [SLOT_W-1:0] free_slot_r, free_slot_nxt;
  logic              best_hit_r, best_hit_nxt;
  logic [SLOT_W-1:0] best_r, best_nxt;
  logic [CNT_W-1:0]  bpos_r, bpos_nxt;

  status_t           res_status_r, res_status_nxt;
  logic              res_wake_r, res_wake_nxt;
  logic [TASK_W-1:0] res_task_r, res_task_nxt;
  logic              res_sleep_r, res_sleep_nxt;
  logic [CNT_W-1:0]  res_count_r, res_count_nxt;

  logic [2:0]        o_status_r, o_status_nxt;
  logic              o_wake_r, o_wake_nxt;
  logic [15:0]       o_task_r, o_task_nxt;
  logic              o_sleep_r, o_sleep_nxt;
  logic [4:0]        o_count_r, o_count_nxt;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [TASK_W-1:0] ram_wdata, ram_rdata;

  logic [CNT_W-1:0]  cur_cnt;
  logic [POS_W-1:0]  cur_head;
  logic              match;
  logic              i_last;

  crrs_ram #(.WIDTH(TASK_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < MAX_CONTAINERS; k++) begin
        valid_r[k] <= 1'b0;
        rank_r[k]  <= '0;
        count_r[k] <= '0;
        head_r[k]  <= '0;
      end
    end else begin
      for (int k = 0; k < MAX_CONTAINERS; k++) begin
        valid_r[k] <= valid_nxt[k];
        rank_r[k]  <= rank_nxt[k];
        count_r[k] <= count_nxt[k];
        head_r[k]  <= head_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < MAX_CONTAINERS; k++) key_r[k] <= key_nxt[k];
    req_r         <= req_nxt;
    rkey_r        <= rkey_nxt;
    task_r        <= task_nxt;
    s_idx_r       <= s_idx_nxt;
    cur_r         <= cur_nxt;
    i_r           <= i_nxt;
    key_hit_r     <= key_hit_nxt;
    key_slot_r    <= key_slot_nxt;
    free_hit_r    <= free_hit_nxt;
    free_slot_r   <= free_slot_nxt;
    best_hit_r    <= best_hit_nxt;
    best_r        <= best_nxt;
    bpos_r        <= bpos_nxt;
    res_status_r  <= res_status_nxt;
    res_wake_r    <= res_wake_nxt;
    res_task_r    <= res_task_nxt;
    res_sleep_r   <= res_sleep_nxt;
    res_count_r   <= res_count_nxt;
    o_status_r    <= o_status_nxt;
    o_wake_r      <= o_wake_nxt;
    o_task_r      <= o_task_nxt;
    o_sleep_r     <= o_sleep_nxt;
    o_count_r     <= o_count_nxt;
  end

  assign cur_cnt  = count_r[cur_r];
  assign cur_head = head_r[cur_r];
  assign match    = (ram_rdata == task_r);
  assign i_last   = ((i_r + CNT_W'(1)) == cur_cnt);

  always_comb begin
    for (int k = 0; k < MAX_CONTAINERS; k++) begin
      valid_nxt[k] = valid_r[k];
      key_nxt[k]   = key_r[k];
      rank_nxt[k]  = rank_r[k];
      count_nxt[k] = count_r[k];
      head_nxt[k]  = head_r[k];
    end
    req_nxt        = req_r;
    rkey_nxt       = rkey_r;
    task_nxt       = task_r;
    s_idx_nxt      = s_idx_r;
    cur_nxt        = cur_r;
    i_nxt          = i_r;
    key_hit_nxt    = key_hit_r;
    key_slot_nxt   = key_slot_r;
    free_hit_nxt   = free_hit_r;
    free_slot_nxt  = free_slot_r;
    best_hit_nxt   = best_hit_r;
    best_nxt       = best_r;
    bpos_nxt       = bpos_r;
    res_status_nxt = res_status_r;
    res_wake_nxt   = res_wake_r;
    res_task_nxt   = res_task_r;
    res_sleep_nxt  = res_sleep_r;
    res_count_nxt  = res_count_r;
    o_status_nxt   = o_status_r;
    o_wake_nxt     = o_wake_r;
    o_task_nxt     = o_task_r;
    o_sleep_nxt    = o_sleep_r;
    o_count_nxt    = o_count_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = task_r;
    ram_raddr      = '0;

    unique case (cmd.op)
      OP_NONE: begin
      end
      OP_LOAD: begin
        req_nxt        = req_t'(in_req_type);
        rkey_nxt       = in_container_id;
        task_nxt       = TASK_W'(in_task_id);
        s_idx_nxt      = '0;
        i_nxt          = '0;
        key_hit_nxt    = 1'b0;
        free_hit_nxt   = 1'b0;
        best_hit_nxt   = 1'b0;
        res_status_nxt = STAT_DONE;
        res_wake_nxt   = 1'b0;
        res_task_nxt   = '0;
        res_sleep_nxt  = 1'b0;
        res_count_nxt  = '0;
      end
      OP_KEY_STEP: begin
        if (valid_r[s_idx_r] && key_r[s_idx_r] == rkey_r && !key_hit_r) begin
          key_hit_nxt  = 1'b1;
          key_slot_nxt = s_idx_r;
        end
        if (!valid_r[s_idx_r] && !free_hit_r) begin
          free_hit_nxt  = 1'b1;
          free_slot_nxt = s_idx_r;
        end
        s_idx_nxt = s_idx_r + SLOT_W'(1);
      end
      OP_CREATE: begin
        if (key_hit_r) begin
          res_count_nxt = count_r[key_slot_r];
          if (count_r[key_slot_r] >= CNT_W'(QUEUE_DEPTH)) begin
            res_status_nxt = STAT_FULL;
          end else begin
            ram_we                = 1'b1;
            ram_waddr             = qaddr(key_slot_r, head_r[key_slot_r],
                                          count_r[key_slot_r]);
            count_nxt[key_slot_r] = count_r[key_slot_r] + CNT_W'(1);
            res_count_nxt         = count_r[key_slot_r] + CNT_W'(1);
            res_sleep_nxt         = (count_r[key_slot_r] != '0);
          end
        end else if (!free_hit_r) begin
          res_status_nxt = STAT_FULL;
        end else begin
          for (int k = 0; k < MAX_CONTAINERS; k++) begin
            if (valid_r[k]) rank_nxt[k] = rank_r[k] + SLOT_W'(1);
          end
          valid_nxt[free_slot_r] = 1'b1;
          key_nxt[free_slot_r]   = rkey_r;
          rank_nxt[free_slot_r]  = '0;
          count_nxt[free_slot_r] = CNT_W'(1);
          head_nxt[free_slot_r]  = '0;
          ram_we                 = 1'b1;
          ram_waddr              = qaddr(free_slot_r, '0, '0);
          res_count_nxt          = CNT_W'(1);
        end
      end
      OP_DEL_EVAL: begin
        if (!key_hit_r) begin
          res_status_nxt = STAT_NO_CONT;
        end else if (count_r[key_slot_r] <= CNT_W'(1)) begin
          for (int k = 0; k < MAX_CONTAINERS; k++) begin
            if (valid_r[k] && SLOT_W'(k) != key_slot_r &&
                rank_r[k] > rank_r[key_slot_r]) begin
              rank_nxt[k] = rank_r[k] - SLOT_W'(1);
            end
          end
          valid_nxt[key_slot_r] = 1'b0;
          count_nxt[key_slot_r] = '0;
          rank_nxt[key_slot_r]  = '0;
          head_nxt[key_slot_r]  = '0;
        end else begin
          cur_nxt = key_slot_r;
          i_nxt   = '0;
        end
      end
      OP_TASK_RD: ram_raddr = qaddr(cur_r, cur_head, i_r);
      OP_DEL_CMP: begin
        if (match) begin
          bpos_nxt = i_r;
        end else if (i_last) begin
          res_status_nxt = STAT_NO_TASK;
          res_count_nxt  = cur_cnt;
        end else begin
          i_nxt = i_r + CNT_W'(1);
        end
      end
      OP_DEL_HIT: begin
        if (bpos_r == '0) begin
          head_nxt[cur_r]  = next_pos(cur_head);
          count_nxt[cur_r] = cur_cnt - CNT_W'(1);
        end
      end
      OP_SW_SEL: begin
        cur_nxt = s_idx_r;
        i_nxt   = '0;
      end
      OP_S_INC: s_idx_nxt = s_idx_r + SLOT_W'(1);
      OP_SW_CMP: begin
        if (match && (!best_hit_r || rank_r[cur_r] < rank_r[best_r])) begin
          best_hit_nxt = 1'b1;
          best_nxt     = cur_r;
          bpos_nxt     = i_r;
        end
        if (match || i_last) s_idx_nxt = s_idx_r + SLOT_W'(1);
        else                 i_nxt     = i_r + CNT_W'(1);
      end
      OP_SW_EVAL: begin
        if (!best_hit_r) begin
          res_status_nxt = STAT_NO_TASK;
        end else if (count_r[best_r] <= CNT_W'(1)) begin
          res_status_nxt = STAT_SOLE;
          res_count_nxt  = count_r[best_r];
        end else begin
          cur_nxt = best_r;
          if (bpos_r == '0) begin
            head_nxt[best_r] = next_pos(head_r[best_r]);
            ram_we           = 1'b1;
            ram_waddr        = qaddr(best_r, head_r[best_r], count_r[best_r]);
          end else begin
            i_nxt = bpos_r;
          end
        end
      end
      OP_SH_RD: ram_raddr = qaddr(cur_r, cur_head, i_r + CNT_W'(1));
      OP_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = qaddr(cur_r, cur_head, i_r);
        ram_wdata = ram_rdata;
        i_nxt     = i_r + CNT_W'(1);
      end
      OP_SH_END: begin
        if (req_r == REQ_SWITCH) begin
          ram_we    = 1'b1;
          ram_waddr = qaddr(cur_r, cur_head, cur_cnt - CNT_W'(1));
        end else begin
          count_nxt[cur_r] = cur_cnt - CNT_W'(1);
        end
      end
      OP_WAKE_RD: ram_raddr = qaddr(cur_r, cur_head, '0);
      OP_WAKE_CAP: begin
        res_status_nxt = STAT_DONE;
        res_wake_nxt   = 1'b1;
        res_task_nxt   = ram_rdata;
        res_sleep_nxt  = (req_r == REQ_SWITCH);
        res_count_nxt  = cur_cnt;
      end
      OP_PUBLISH: begin
        o_status_nxt = res_status_r;
        o_wake_nxt   = res_wake_r;
        o_task_nxt   = 16'(res_task_r);
        o_sleep_nxt  = res_sleep_r;
        o_count_nxt  = 5'(res_count_r);
      end
      default: begin
      end
    endcase
  end

  assign st.req         = req_r;
  assign st.s_last      = (s_idx_r == SLOT_W'(MAX_CONTAINERS - 1));
  assign st.slot_ok     = valid_r[s_idx_r];
  assign st.match       = match;
  assign st.i_last      = i_last;
  assign st.best_hit    = best_hit_r;
  assign st.best_single = (count_r[best_r] <= CNT_W'(1));
  assign st.bpos_zero   = (bpos_r == '0);
  assign st.key_hit     = key_hit_r;
  assign st.key_single  = (count_r[key_slot_r] <= CNT_W'(1));
  assign st.sh_more     = ((i_r + CNT_W'(1)) < cur_cnt);

  assign out_status        = o_status_r;
  assign out_wake_valid    = o_wake_r;
  assign out_wake_task     = o_task_r;
  assign out_caller_sleeps = o_sleep_r;
  assign out_task_count    = o_count_r;

endmodule

FILE: dv/container_round_robin_scheduler_test.sv
// ----------------------------------------------------------------------------
// container_round_robin_scheduler_test
// Drives create, switch, delete and no-op requests with random gaps on both
// sides; checks every result against a cycle-free scheduler model in the bench.
// ----------------------------------------------------------------------------
module container_round_robin_scheduler_test;
  import crrs_pkg::*;

  typedef struct packed {
    req_t        req;
    logic [31:0] cid;
    logic [15:0] tid;
  } sched_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        wake_valid;
    logic [15:0] wake_task;
    logic        sleeps;
    logic [4:0]  count;
  } sched_rsp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = '0;
  logic [31:0] in_container_id = '0;
  logic [15:0] in_task_id = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic        out_wake_valid;
  logic [15:0] out_wake_task;
  logic        out_caller_sleeps;
  logic [4:0]  out_task_count;

  always #2 clk = ~clk;

  container_round_robin_scheduler u_dut (.*);

  bit          c_live [MAX_CONTAINERS];
  logic [31:0] c_key  [MAX_CONTAINERS];
  int          c_rank [MAX_CONTAINERS];
  logic [15:0] c_tasks[MAX_CONTAINERS][$];

  sched_req_t pending_reqs[$];
  sched_rsp_t expected_rsps[$];
  int         errors = 0;
  int         cycles = 0;
  int         in_wait = 0;
  int         out_wait = 0;
  bit         hold_off = 1'b0;

  function automatic int lookup_key(logic [31:0] key);
    for (int s = 0; s < MAX_CONTAINERS; s++)
      if (c_live[s] && c_key[s] == key) return s;
    return -1;
  endfunction

  function automatic int pos_of(int s, logic [15:0] t);
    for (int i = 0; i < c_tasks[s].size(); i++)
      if (c_tasks[s][i] == t) return i;
    return -1;
  endfunction

  function automatic sched_rsp_t schedule(sched_req_t r);
    sched_rsp_t o;
    int s, k, p, best, bpos;
    o = '0;
    case (r.req)
      REQ_CREATE: begin
        s = lookup_key(r.cid);
        if (s >= 0) begin
          if (c_tasks[s].size() >= QUEUE_DEPTH) o.status = STAT_FULL;
          else begin
            c_tasks[s].push_back(r.tid);
            o.sleeps = (c_tasks[s].size() > 1);
          end
          o.count = 5'(c_tasks[s].size());
        end else begin
          k = 0;
          while (k < MAX_CONTAINERS && c_live[k]) k++;
          if (k >= MAX_CONTAINERS) o.status = STAT_FULL;
          else begin
            for (int j = 0; j < MAX_CONTAINERS; j++) if (c_live[j]) c_rank[j]++;
            c_live[k] = 1'b1; c_key[k] = r.cid; c_rank[k] = 0;
            c_tasks[k] = {r.tid};
            o.count = 5'd1;
          end
        end
      end
      REQ_SWITCH: begin
        best = -1; bpos = -1;
        for (k = 0; k < MAX_CONTAINERS; k++) begin
          if (!c_live[k]) continue;
          p = pos_of(k, r.tid);
          if (p >= 0 && (best < 0 || c_rank[k] < c_rank[best])) begin
            best = k; bpos = p;
          end
        end
        if (best < 0) o.status = STAT_NO_TASK;
        else if (c_tasks[best].size() <= 1) begin
          o.status = STAT_SOLE; o.count = 5'(c_tasks[best].size());
        end else begin
          c_tasks[best].delete(bpos);
          c_tasks[best].push_back(r.tid);
          o.wake_valid = 1'b1; o.wake_task = c_tasks[best][0];
          o.sleeps = 1'b1; o.count = 5'(c_tasks[best].size());
        end
      end
      REQ_DELETE: begin
        s = lookup_key(r.cid);
        if (s < 0) o.status = STAT_NO_CONT;
        else if (c_tasks[s].size() <= 1) begin
          for (k = 0; k < MAX_CONTAINERS; k++)
            if (c_live[k] && k != s && c_rank[k] > c_rank[s]) c_rank[k]--;
          c_live[s] = 1'b0; c_rank[s] = 0; c_tasks[s] = {};
        end else begin
          p = pos_of(s, r.tid);
          if (p < 0) o.status = STAT_NO_TASK;
          else begin
            c_tasks[s].delete(p);
            o.wake_valid = 1'b1; o.wake_task = c_tasks[s][0];
          end
          o.count = 5'(c_tasks[s].size());
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic sched_req_t mk(req_t q, logic [31:0] c, logic [15:0] t);
    sched_req_t r;
    r.req = q; r.cid = c; r.tid = t;
    return r;
  endfunction

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 9))
      0:       return $urandom();
      1:       return 32'hFFFF_FFF0 | 32'($urandom_range(0, 15));
      default: return 32'($urandom_range(0, 19)) | ($urandom_range(0, 1) ? 32'hA5A5_0000 : 0);
    endcase
  endfunction

  function automatic logic [15:0] rand_task();
    if ($urandom_range(0, 7) == 0) return 16'($urandom());
    return 16'($urandom_range(0, 11)) | ($urandom_range(0, 1) ? 16'hF000 : 16'h0);
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 5_000_000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(schedule(mk(req_t'(in_req_type), in_container_id,
                                            in_task_id)));
        in_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      end
      if (!(in_valid && !in_ready)) begin
        if (in_wait > 0) begin
          in_wait--;
          in_valid <= 1'b0;
        end else if (!hold_off && pending_reqs.size() > 0) begin
          sched_req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_req_type <= r.req;
          in_container_id <= r.cid;
          in_task_id <= r.tid;
        end else in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsps.size() == 0) begin
          $error("unexpected result transfer");
          errors++;
        end else begin
          sched_rsp_t e;
          e = expected_rsps.pop_front();
          if (out_status !== e.status) begin
            $error("status exp %0d got %0d", e.status, out_status); errors++;
          end
          if (out_wake_valid !== e.wake_valid) begin
            $error("wake_valid exp %0d got %0d", e.wake_valid, out_wake_valid); errors++;
          end
          if (out_wake_task !== e.wake_task) begin
            $error("wake_task exp %0d got %0d", e.wake_task, out_wake_task); errors++;
          end
          if (out_caller_sleeps !== e.sleeps) begin
            $error("caller_sleeps exp %0d got %0d", e.sleeps, out_caller_sleeps); errors++;
          end
          if (out_task_count !== e.count) begin
            $error("task_count exp %0d got %0d", e.count, out_task_count); errors++;
          end
        end
        out_wait = $urandom_range(0, 1) ? 0 : $urandom_range(0, 14);
      end
      if (out_wait > 0) begin
        out_wait--;
        out_ready <= 1'b0;
      end else out_ready <= 1'b1;
    end
  end

  initial begin
    int n;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    pending_reqs.push_back(mk(REQ_SWITCH, 32'h0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_DELETE, 32'hFFFF_FFFF, 16'h0));
    pending_reqs.push_back(mk(REQ_NOP, 32'h1234_5678, 16'h00FF));
    pending_reqs.push_back(mk(REQ_CREATE, 32'h0, 16'h0));
    pending_reqs.push_back(mk(REQ_SWITCH, 32'h0, 16'h0));
    pending_reqs.push_back(mk(REQ_CREATE, 32'h0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_CREATE, 32'h0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_CREATE, 32'h0, 16'h0005));
    pending_reqs.push_back(mk(REQ_SWITCH, 32'h0, 16'h0005));
    pending_reqs.push_back(mk(REQ_SWITCH, 32'h0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_DELETE, 32'h0, 16'h0077));
    pending_reqs.push_back(mk(REQ_DELETE, 32'h0, 16'h0005));
    pending_reqs.push_back(mk(REQ_DELETE, 32'h0, 16'hFFFF));
    pending_reqs.push_back(mk(REQ_CREATE, 32'hFFFF_FFFF, 16'h0001));
    pending_reqs.push_back(mk(REQ_DELETE, 32'hFFFF_FFFF, 16'h0099));
    pending_reqs.push_back(mk(REQ_DELETE, 32'hFFFF_FFFF, 16'h0099));
    for (int i = 0; i < 17; i++) pending_reqs.push_back(mk(REQ_CREATE, 32'h77, 16'(i)));
    for (int i = 0; i < 17; i++) pending_reqs.push_back(mk(REQ_CREATE, 32'(i + 1), 16'h3));
    pending_reqs.push_back(mk(REQ_SWITCH, 32'h0, 16'h3));
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    hold_off = 1'b1;
    repeat (40) @(posedge clk);
    hold_off = 1'b0;
    for (int i = 0; i < 18; i++) pending_reqs.push_back(mk(REQ_DELETE, 32'(i), 16'h3));
    pending_reqs.push_back(mk(REQ_DELETE, 32'h77, 16'h0));
    n = 0;
    while (n < 1700) begin
      if (pending_reqs.size() < 4) begin
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
          pending_reqs.push_back(mk(REQ_CREATE, rand_key(), rand_task()));
        else if (roll < 70)
          pending_reqs.push_back(mk(REQ_SWITCH, $urandom(), rand_task()));
        else if (roll < 97)
          pending_reqs.push_back(mk(REQ_DELETE, rand_key(), rand_task()));
        else
          pending_reqs.push_back(mk(REQ_NOP, $urandom(), 16'($urandom())));
        n++;
      end
      @(posedge clk);
    end
    while (pending_reqs.size() > 0 || in_valid || expected_rsps.size() > 0)
      @(posedge clk);
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
